[sv/dtf_pkg.sv]
`timescale 1ns / 1ps

package dtf_pkg;

    localparam int FIFO_DEPTH = 128;
    localparam int ADDR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int FILL_W     = 8;
    localparam int STAMP_W    = 64;
    localparam int MS_W       = 32;
    localparam int GAP_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [GAP_W-1:0] DEBOUNCE_RST = GAP_W'(80);
    localparam logic [GAP_W-1:0] PULSE_RST    = GAP_W'(500);

    // item codes
    localparam logic [1:0] MODE_EDGE  = 2'd0;
    localparam logic [1:0] MODE_FLUSH = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MILLIS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE      = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [1:0]      mode;
        logic [MS_W-1:0] now_ms;
        logic            link_up;
        logic            send_ok;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic               stored;
        logic               dropped;
        logic               led_toggle;
        logic [STAMP_W-1:0] event_time_ms;
        logic               popped;
        logic               disconnect_request;
        logic [FILL_W-1:0]  fill_level;
        logic               detected;
    } t_out_item;

endpackage

[sv/dtf_ram.sv]
`timescale 1ns / 1ps

module dtf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read of the entry being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/debounced_event_timestamp_fifo_core.sv]
`timescale 1ns / 1ps

// Debounced switch-edge capture with an epoch timestamp FIFO. Each input transfer is
// a switch edge, a flush report, a clear of the detected flag or a spare code, and
// gives exactly one result transfer. An edge counts when its 32-bit wrapping gap
// from the last counted edge is strictly above debounce_ms; it is stamped
// epoch_base_ms + (now_ms - millis_base) and pushed into a FIFO_DEPTH-entry store,
// or dropped when the store is full (with an LED toggle pulse at most once per
// pulse_interval_ms). A flush with entries and the link up returns the head stamp
// and pops it when send_ok is set, otherwise it raises disconnect_request. An item
// is latched while the store's registered read port presents the head entry, then
// executed. The result register frees the input side, so the next item is taken
// while a result still waits; that item then holds in execute until that result
// transfers. Registers are to be written only when idle; the block never checks.
module debounced_event_timestamp_fifo_core
    import dtf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out
);

    // configuration
    logic [STAMP_W-1:0] r_epoch_base;
    logic [MS_W-1:0]    r_millis_base;
    logic [GAP_W-1:0]   r_debounce;
    logic [GAP_W-1:0]   r_pulse_interval;

    // FIFO pointers and timing state
    logic [ADDR_W-1:0]  r_head,        n_head;
    logic [CNT_W-1:0]   r_count,       n_count;
    logic [MS_W-1:0]    r_last_accept, n_last_accept;
    logic [MS_W-1:0]    r_last_pulse,  n_last_pulse;
    logic               r_detected,    n_detected;

    t_state             r_state, n_state;
    t_in_item           r_in;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               in_xfer;
    logic               commit;

    // datapath
    logic [MS_W-1:0]    accept_gap;
    logic [MS_W-1:0]    pulse_gap;
    logic [MS_W-1:0]    local_ms;
    logic [STAMP_W-1:0] stamp;
    logic               edge_ok;
    logic               pulse_ok;
    logic               fifo_full;
    logic               flush_go;
    logic [SUM_W-1:0]   tail_sum;
    logic [ADDR_W-1:0]  tail;
    logic               ram_we;
    logic [STAMP_W-1:0] head_data;

    dtf_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tail),
        .i_wdata (stamp),
        .i_raddr (r_head),
        .o_rdata (head_data)
    );

    // head is always being read; it only moves in an execute cycle, and an item
    // executes no sooner than the cycle after its transfer, so head_data is current
    assign in_xfer = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_xfer) n_state = S_EXEC;
            S_EXEC:  if (commit)  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        commit     = 1'b0;
        case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_EXEC:  commit     = !r_out_valid || !i_out_stall;
            default: o_in_stall = 1'b1;
        endcase
    end

    // debounce, stamp and FIFO address arithmetic
    assign accept_gap = r_in.now_ms - r_last_accept;
    assign pulse_gap  = r_in.now_ms - r_last_pulse;
    assign local_ms   = r_in.now_ms - r_millis_base;
    assign stamp      = r_epoch_base + STAMP_W'(local_ms);
    assign edge_ok    = accept_gap > MS_W'(r_debounce);
    assign pulse_ok   = pulse_gap > MS_W'(r_pulse_interval);
    assign fifo_full  = r_count == CNT_W'(FIFO_DEPTH);
    assign flush_go   = (r_count != '0) && r_in.link_up;

    // tail wraps with one compare and subtract
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
    assign tail     = (tail_sum >= SUM_W'(FIFO_DEPTH)) ?
                      ADDR_W'(tail_sum - SUM_W'(FIFO_DEPTH)) : ADDR_W'(tail_sum);

    assign ram_we = commit && (r_in.mode == MODE_EDGE) && edge_ok && !fifo_full;

    // execute: next pointers, flag and result
    always_comb begin
        n_head        = r_head;
        n_count       = r_count;
        n_last_accept = r_last_accept;
        n_last_pulse  = r_last_pulse;
        n_detected    = r_detected;
        n_out         = '0;
        case (r_in.mode)
            MODE_EDGE: begin
                if (edge_ok) begin
                    n_last_accept       = r_in.now_ms;
                    n_detected          = 1'b1;
                    n_out.accepted      = 1'b1;
                    n_out.event_time_ms = stamp;
                    if (!fifo_full) begin
                        n_count      = r_count + CNT_W'(1);
                        n_out.stored = 1'b1;
                    end else begin
                        n_out.dropped = 1'b1;
                        if (pulse_ok) begin
                            n_last_pulse     = r_in.now_ms;
                            n_out.led_toggle = 1'b1;
                        end
                    end
                end
            end
            MODE_FLUSH: begin
                if (flush_go) begin
                    n_out.event_time_ms = head_data;
                    if (r_in.send_ok) begin
                        n_head       = (r_head == ADDR_W'(FIFO_DEPTH - 1)) ?
                                       '0 : r_head + ADDR_W'(1);
                        n_count      = r_count - CNT_W'(1);
                        n_out.popped = 1'b1;
                    end else begin
                        n_out.disconnect_request = 1'b1;
                    end
                end
            end
            MODE_CLEAR: n_detected = 1'b0;
            default:    n_detected = r_detected;
        endcase
        n_out.fill_level = FILL_W'(n_count);
        n_out.detected   = n_detected;
    end

    // result register holds until the downstream transfer
    assign n_out_valid = commit || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_out_valid      <= 1'b0;
            r_head           <= '0;
            r_count          <= '0;
            r_last_accept    <= '0;
            r_last_pulse     <= '0;
            r_detected       <= 1'b0;
            r_epoch_base     <= '0;
            r_millis_base    <= '0;
            r_debounce       <= DEBOUNCE_RST;
            r_pulse_interval <= PULSE_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (commit) begin
                r_head        <= n_head;
                r_count       <= n_count;
                r_last_accept <= n_last_accept;
                r_last_pulse  <= n_last_pulse;
                r_detected    <= n_detected;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EPOCH_BASE: r_epoch_base     <= i_cfg_data;
                    CFG_MILLIS:     r_millis_base    <= i_cfg_data[MS_W-1:0];
                    CFG_DEBOUNCE:   r_debounce       <= i_cfg_data[GAP_W-1:0];
                    CFG_PULSE:      r_pulse_interval <= i_cfg_data[GAP_W-1:0];
                    default:        r_epoch_base     <= r_epoch_base;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // the entry count never passes the store depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("entry count above fifo depth");

    // a stored edge always leaves at least one entry behind it
    a_stored_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stored) |-> (r_out.fill_level != '0))
        else $error("stored result with empty fifo");

    // an executing item finishes as soon as the result register is free
    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !(r_out_valid && i_out_stall)) |=> (r_state == S_IDLE))
        else $error("execute did not complete with free result register");

    // a pop and a store never come from one item
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.popped && r_out.accepted))
        else $error("result mixes flush and edge outcomes");

endmodule

[sim/debounced_event_timestamp_fifo_core_test.sv]
`timescale 1ns / 1ps

module debounced_event_timestamp_fifo_core_test;

    import dtf_pkg::*;

    // the spare mode code, which the block must ignore
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int OPEN_ROWS     = 19;
    localparam int SETTING_LAPS  = 8;
    localparam int ITEMS_PER_LAP = 217;
    // worst quiet stretch: a sender gap, a sink stall, the pipeline and a drain plus
    // register writes; taken many times over
    localparam int QUIET_LIMIT   = 600;

    typedef struct {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_opening_row;

    // block ports; the inputs are known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out;

    // mirror of the registers
    logic [STAMP_W-1:0] epoch_reg = '0;
    logic [MS_W-1:0]    base_reg  = '0;
    logic [GAP_W-1:0]   gap_reg   = DEBOUNCE_RST;
    logic [GAP_W-1:0]   flash_reg = PULSE_RST;

    // mirror of the capture state
    logic [STAMP_W-1:0] stamp_ring [FIFO_DEPTH];
    logic [ADDR_W-1:0]  ring_head     = '0;
    logic [CNT_W-1:0]   ring_count    = '0;
    logic [MS_W-1:0]    last_take_ms  = '0;
    logic [MS_W-1:0]    last_flash_ms = '0;
    logic               flag_seen     = 1'b0;

    t_out_item pending_results [$];

    // running tallies for the summary
    int items_sent, results_seen, fault_count, quiet_cycles;
    int n_taken, n_stored, n_dropped, n_flash, n_popped, n_refused;

    // result sink pacing
    int   sink_hold = 0;
    logic sink_lazy = 1'b1;

    // local millisecond clock fed to the edges, advanced only when an edge is made
    logic [MS_W-1:0] wall_ms = '0;

    debounced_event_timestamp_fifo_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // expected outcome of one item, advancing the mirrored state
    function automatic t_out_item capture_step(input t_in_item it);
        t_out_item         r;
        logic [MS_W-1:0]   since;
        logic [ADDR_W-1:0] tail;
        r = '0;
        case (it.mode)
            MODE_EDGE: begin
                // wrapping gap from the last counted edge must strictly exceed debounce
                since = it.now_ms - last_take_ms;
                if (since > MS_W'(gap_reg)) begin
                    last_take_ms    = it.now_ms;
                    r.accepted      = 1'b1;
                    since           = it.now_ms - base_reg;
                    r.event_time_ms = epoch_reg + STAMP_W'(since);
                    n_taken++;
                    if (ring_count < FIFO_DEPTH) begin
                        tail = ADDR_W'((int'(ring_head) + int'(ring_count))
                                       % FIFO_DEPTH);
                        stamp_ring[tail] = r.event_time_ms;
                        ring_count++;
                        r.stored = 1'b1;
                        n_stored++;
                    end else begin
                        // full: edge lost, led pulse rate limited by its own gap
                        r.dropped = 1'b1;
                        n_dropped++;
                        since = it.now_ms - last_flash_ms;
                        if (since > MS_W'(flash_reg)) begin
                            last_flash_ms = it.now_ms;
                            r.led_toggle  = 1'b1;
                            n_flash++;
                        end
                    end
                    flag_seen = 1'b1;
                end
            end
            MODE_FLUSH: begin
                // nothing happens with an empty store or the link down
                if (ring_count != 0 && it.link_up) begin
                    r.event_time_ms = stamp_ring[ring_head];
                    if (it.send_ok) begin
                        ring_head = ADDR_W'((int'(ring_head) + 1) % FIFO_DEPTH);
                        ring_count--;
                        r.popped = 1'b1;
                        n_popped++;
                    end else begin
                        r.disconnect_request = 1'b1;
                        n_refused++;
                    end
                end
            end
            MODE_CLEAR: begin
                flag_seen = 1'b0;
            end
            default: begin
            end
        endcase
        r.fill_level = FILL_W'(ring_count);
        r.detected   = flag_seen;
        return r;
    endfunction

    function automatic string show_result(input t_out_item r);
        return $sformatf({"acc=%0b sto=%0b drp=%0b led=%0b stamp=%h ",
                          "pop=%0b disc=%0b fill=%0d det=%0b"},
            r.accepted, r.stored, r.dropped, r.led_toggle, r.event_time_ms,
            r.popped, r.disconnect_request, r.fill_level, r.detected);
    endfunction

    function automatic string field_diff(input t_out_item want, input t_out_item got);
        string s;
        s = "";
        if (got.accepted !== want.accepted) s = {s, " accepted"};
        if (got.stored !== want.stored) s = {s, " stored"};
        if (got.dropped !== want.dropped) s = {s, " dropped"};
        if (got.led_toggle !== want.led_toggle) s = {s, " led_toggle"};
        if (got.event_time_ms !== want.event_time_ms) s = {s, " event_time_ms"};
        if (got.popped !== want.popped) s = {s, " popped"};
        if (got.disconnect_request !== want.disconnect_request) s = {s, " disconnect_request"};
        if (got.fill_level !== want.fill_level) s = {s, " fill_level"};
        if (got.detected !== want.detected) s = {s, " detected"};
        return s;
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // result side: check every transfer against the oldest pending expectation
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        string     bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                note_fault($sformatf("result with nothing pending: %s", show_result(o_out)));
            end else begin
                want = pending_results.pop_front();
                bad  = field_diff(want, o_out);
                if (bad != "") begin
                    note_fault($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
                        bad, show_result(want), show_result(o_out)));
                end
            end
            results_seen++;
            // sink alternates between busy stretches and stretches with no stalls
            if (results_seen % 64 == 0) begin
                sink_lazy = 1'($urandom_range(0, 1));
            end
            sink_hold = sink_lazy ? $urandom_range(0, 19) : 0;
        end
        // watchdog bookkeeping: any transfer on either side counts as progress
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
    end

    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            i_out_stall <= 1'b1;
            sink_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("no transfer for %0d cycles, %0d results still pending",
            QUIET_LIMIT, pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // one input transfer after a gap; valid stays high when the gap is zero
    task automatic offer_item(input t_in_item it, input logic typed, input t_out_item want,
                              input int gap);
        t_out_item predicted;
        predicted = capture_step(it);
        pending_results.push_back(typed ? want : predicted);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in       <= it;
        i_in_valid <= 1'b1;
        items_sent++;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // hold off the sender until every result is back, then let the pipe settle
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_EPOCH_BASE: epoch_reg = val;
            CFG_MILLIS:     base_reg  = val[MS_W-1:0];
            CFG_DEBOUNCE:   gap_reg   = val[GAP_W-1:0];
            CFG_PULSE:      flash_reg = val[GAP_W-1:0];
            default: begin
            end
        endcase
    endtask

    initial begin : stimulus
        t_opening_row opening [OPEN_ROWS];
        t_in_item     it;
        int           seg_left, edge_pct, gap, lap, n, pick;
        logic         send_lazy;

        // opening sequence under reset defaults: debounce 80, pulse 500, zero bases
        opening[0]  = '{'{MODE_FLUSH, 32'd0, 1'b1, 1'b1}, 1'b1,
                        '{0, 0, 0, 0, 64'd0, 0, 0, 8'd0, 0}};
        opening[1]  = '{'{MODE_CLEAR, 32'd0, 1'b0, 1'b0}, 1'b1,
                        '{0, 0, 0, 0, 64'd0, 0, 0, 8'd0, 0}};
        opening[2]  = '{'{MODE_SPARE, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1,
                        '{0, 0, 0, 0, 64'd0, 0, 0, 8'd0, 0}};
        // gap equal to debounce is rejected, one more is taken
        opening[3]  = '{'{MODE_EDGE, 32'd80, 1'b1, 1'b1}, 1'b1,
                        '{0, 0, 0, 0, 64'd0, 0, 0, 8'd0, 0}};
        opening[4]  = '{'{MODE_EDGE, 32'd81, 1'b0, 1'b0}, 1'b1,
                        '{1, 1, 0, 0, 64'd81, 0, 0, 8'd1, 1}};
        opening[5]  = '{'{MODE_EDGE, 32'd161, 1'b0, 1'b1}, 1'b1,
                        '{0, 0, 0, 0, 64'd0, 0, 0, 8'd1, 1}};
        opening[6]  = '{'{MODE_EDGE, 32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b1,
                        '{1, 1, 0, 0, 64'hFFFF_FFFF, 0, 0, 8'd2, 1}};
        // counter wraps past zero: gap is still 81
        opening[7]  = '{'{MODE_EDGE, 32'd80, 1'b0, 1'b0}, 1'b0, '0};
        // link down: send outcome ignored
        opening[8]  = '{'{MODE_FLUSH, 32'd5, 1'b0, 1'b1}, 1'b1,
                        '{0, 0, 0, 0, 64'd0, 0, 0, 8'd3, 1}};
        opening[9]  = '{'{MODE_FLUSH, 32'd6, 1'b1, 1'b0}, 1'b1,
                        '{0, 0, 0, 0, 64'd81, 0, 1, 8'd3, 1}};
        opening[10] = '{'{MODE_FLUSH, 32'd7, 1'b1, 1'b1}, 1'b1,
                        '{0, 0, 0, 0, 64'd81, 1, 0, 8'd2, 1}};
        opening[11] = '{'{MODE_CLEAR, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1,
                        '{0, 0, 0, 0, 64'd0, 0, 0, 8'd2, 0}};
        opening[12] = '{'{MODE_EDGE, 32'd160, 1'b0, 1'b0}, 1'b0, '0};
        opening[13] = '{'{MODE_EDGE, 32'd161, 1'b0, 1'b0}, 1'b0, '0};
        opening[14] = '{'{MODE_FLUSH, 32'd0, 1'b1, 1'b1}, 1'b0, '0};
        opening[15] = '{'{MODE_FLUSH, 32'd0, 1'b1, 1'b1}, 1'b0, '0};
        opening[16] = '{'{MODE_FLUSH, 32'd0, 1'b1, 1'b1}, 1'b0, '0};
        // empty store with a failed send: no disconnect
        opening[17] = '{'{MODE_FLUSH, 32'd0, 1'b1, 1'b0}, 1'b1,
                        '{0, 0, 0, 0, 64'd0, 0, 0, 8'd0, 1}};
        opening[18] = '{'{MODE_SPARE, 32'd0, 1'b0, 1'b0}, 1'b0, '0};

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < OPEN_ROWS; n++) begin
            offer_item(opening[n].stim, opening[n].typed, opening[n].want,
                       $urandom_range(0, 19));
        end

        for (lap = 0; lap < SETTING_LAPS; lap++) begin
            // registers change only with the block idle
            drain_results();
            case (lap)
                0: begin
                    write_reg(CFG_EPOCH_BASE, '0);
                    write_reg(CFG_MILLIS, '0);
                    write_reg(CFG_DEBOUNCE, '0);
                    write_reg(CFG_PULSE, '0);
                end
                1: begin
                    write_reg(CFG_EPOCH_BASE, '1);
                    write_reg(CFG_MILLIS, '1);
                    write_reg(CFG_DEBOUNCE, '1);
                    write_reg(CFG_PULSE, '1);
                end
                default: begin
                    // upper junk bits in the narrow registers must be dropped
                    if ($urandom_range(0, 9) < 6) begin
                        write_reg(CFG_EPOCH_BASE, {$urandom, $urandom});
                    end
                    if ($urandom_range(0, 9) < 6) begin
                        write_reg(CFG_MILLIS, {$urandom, $urandom});
                    end
                    if ($urandom_range(0, 9) < 6) begin
                        write_reg(CFG_DEBOUNCE,
                                  {$urandom, 16'($urandom), 16'($urandom_range(0, 200))});
                    end
                    if ($urandom_range(0, 9) < 6) begin
                        write_reg(CFG_PULSE,
                                  {$urandom, 16'($urandom), 16'($urandom_range(0, 1000))});
                    end
                end
            endcase

            seg_left  = 0;
            edge_pct  = 50;
            send_lazy = 1'b0;
            for (n = 0; n < ITEMS_PER_LAP; n++) begin
                // segments: fill bursts that overflow the store, drain bursts, mixes
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 200);
                    pick     = $urandom_range(0, 9);
                    if (pick < 4) begin
                        edge_pct = 90;
                    end else if (pick < 7) begin
                        edge_pct = 15;
                    end else begin
                        edge_pct = 50;
                    end
                    send_lazy = 1'($urandom_range(0, 1));
                end
                seg_left--;

                it.now_ms  = $urandom;
                it.link_up = ($urandom_range(0, 99) < 85);
                it.send_ok = ($urandom_range(0, 99) < 80);
                if ($urandom_range(0, 99) < edge_pct) begin
                    it.mode = MODE_EDGE;
                    // mostly steps past the debounce window, some inside it, rare jumps
                    if ($urandom_range(0, 19) == 0) begin
                        wall_ms = $urandom;
                    end else if ($urandom_range(0, 9) < 7) begin
                        wall_ms += MS_W'(gap_reg) + 32'd1 + $urandom_range(0, gap_reg + 20);
                    end else begin
                        wall_ms += $urandom_range(0, gap_reg);
                    end
                    it.now_ms = wall_ms;
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick < 8) begin
                        it.mode = MODE_FLUSH;
                    end else if (pick == 8) begin
                        it.mode = MODE_CLEAR;
                    end else begin
                        it.mode = MODE_SPARE;
                    end
                end

                gap = send_lazy ? $urandom_range(0, 19) : 0;
                offer_item(it, 1'b0, '0, gap);

                // now and then the sender waits for every result to come back
                if ($urandom_range(0, 99) < 2) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("covered %0d items over %0d register settings, %0d results checked",
            items_sent, SETTING_LAPS + 1, results_seen);
        $display({"edges taken %0d stored %0d dropped %0d led %0d, ",
                  "popped %0d disconnects %0d, faults %0d"},
            n_taken, n_stored, n_dropped, n_flash, n_popped, n_refused, fault_count);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
sv/dtf_pkg.sv
sv/dtf_ram.sv
sv/debounced_event_timestamp_fifo_core.sv
sim/debounced_event_timestamp_fifo_core_test.sv
